// ===== src/lmfe_pkg.sv =====
// ----------------------------------------------------------------------------
// lmfe_pkg
// shared types, codes and the protected identifier function of the lin
// master frame engine
// ----------------------------------------------------------------------------
package lmfe_pkg;

    localparam int MAX_DATA_BYTES = 8;
    localparam int IN_DATA_W      = 88;
    localparam int OUT_DATA_W     = 80;

    localparam logic [7:0] BREAK_BYTE = 8'h00;
    localparam logic [7:0] SYNC_BYTE  = 8'h55;

    typedef enum logic [1:0] {
        CMD_SEND     = 2'd0,
        CMD_TX_READY = 2'd1,
        CMD_RX_BYTE  = 2'd2,
        CMD_FETCH    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BREAK  = 3'd1,
        PH_SYNC   = 3'd2,
        PH_PID    = 3'd3,
        PH_TXDATA = 3'd4,
        PH_RXDATA = 3'd5,
        PH_RXSUM  = 3'd6,
        PH_TXSUM  = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SUM,
        ST_FINISH,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic sum_step;
        logic finish;
        logic load_out;
    } t_ctrl;

    typedef struct packed {
        logic need_sum;
        logic sum_last;
        logic out_busy;
    } t_stat;

    typedef struct packed {
        logic [2:0]  pad;
        logic        checksum_ok;
        logic [63:0] response_data;
        logic        response_valid;
        logic        break_rate;
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        accepted;
    } t_result;

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

endpackage

// ===== src/lin_master_frame_engine.sv =====
// ----------------------------------------------------------------------------
// lin_master_frame_engine
// result: the request is captured, executed and then loaded into the output
//   register; a checksum pass (send with master data, or the received checksum
//   byte) first runs the byte-serial checksum adder over the data bytes
// throughput: one request at a time; the next is taken once the output register is free to load
// reset: synchronous active low; all channels idle, no response pending
// ----------------------------------------------------------------------------
module lin_master_frame_engine #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // channel, frame_id, slave_responds, enhanced_checksum, data_length,
    // frame_data, rx_byte, zero pad
    input  logic [lmfe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // accepted, tx_valid, tx_byte, break_rate, response_valid,
    // response_data, checksum_ok, zero pad
    output logic [lmfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    lmfe_pkg::t_ctrl ctrl;
    lmfe_pkg::t_stat stat;

    lmfe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_ctrl     (ctrl)
    );

    lmfe_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_tdata (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_ctrl_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(ctrl))
        else $error("more than one datapath command at once");

    a_break_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[10]) |->
        (m_axis_tdata[1] && m_axis_tdata[9:2] == lmfe_pkg::BREAK_BYTE))
        else $error("break rate without a break byte");

    a_resp_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[11]) |-> (m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("response reported without an accepted fetch");
`endif

endmodule

// ===== src/lmfe_ctrl.sv =====
// ----------------------------------------------------------------------------
// lmfe_ctrl
// sequencer: takes one request, runs it through execute, the checksum
// pass when needed, and hands the result to the output register
// ----------------------------------------------------------------------------
module lmfe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  lmfe_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output lmfe_pkg::t_ctrl o_ctrl
);

    lmfe_pkg::t_state r_state;
    lmfe_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmfe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_ctrl     = '0;
        case (r_state)
            lmfe_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.load_in = 1'b1;
                    n_state        = lmfe_pkg::ST_EXEC;
                end
            end
            lmfe_pkg::ST_EXEC: begin
                o_ctrl.exec = 1'b1;
                n_state     = i_stat.need_sum ? lmfe_pkg::ST_SUM : lmfe_pkg::ST_OUT;
            end
            lmfe_pkg::ST_SUM: begin
                o_ctrl.sum_step = 1'b1;
                if (i_stat.sum_last) begin
                    n_state = lmfe_pkg::ST_FINISH;
                end
            end
            lmfe_pkg::ST_FINISH: begin
                o_ctrl.finish = 1'b1;
                n_state       = lmfe_pkg::ST_OUT;
            end
            lmfe_pkg::ST_OUT: begin
                if (!i_stat.out_busy) begin
                    o_ctrl.load_out = 1'b1;
                    n_state         = lmfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lmfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lmfe_datapath.sv =====
// ----------------------------------------------------------------------------
// lmfe_datapath
// per-channel frame state, byte sequencing, end-around checksum unit
// (one byte per cycle) and the output register
// ----------------------------------------------------------------------------
module lmfe_datapath #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lmfe_pkg::t_ctrl                     i_ctrl,
    input  logic [lmfe_pkg::IN_DATA_W-1:0]      i_in_tdata,
    input  logic [1:0]                          i_in_tuser,
    input  logic                                i_out_ready,
    output lmfe_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic [lmfe_pkg::OUT_DATA_W-1:0]     o_out_tdata
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // captured request
    lmfe_pkg::t_cmd r_cmd;
    logic [1:0]     r_ch;
    logic [5:0]     r_fid;
    logic           r_sresp;
    logic           r_enh_in;
    logic [3:0]     r_len_in;
    logic [63:0]    r_fdata;
    logic [7:0]     r_rx;

    // per-channel state
    lmfe_pkg::t_phase r_phase [NUM_CHANNELS];
    logic [7:0]       r_pid   [NUM_CHANNELS];
    logic [3:0]       r_idx   [NUM_CHANNELS];
    logic [63:0]      r_data  [NUM_CHANNELS];
    logic [3:0]       r_len   [NUM_CHANNELS];
    logic             r_dir   [NUM_CHANNELS];
    logic             r_enh   [NUM_CHANNELS];
    logic [7:0]       r_csum  [NUM_CHANNELS];
    logic             r_done  [NUM_CHANNELS];
    logic             r_taken [NUM_CHANNELS];
    logic             r_match [NUM_CHANNELS];

    // checksum unit and result
    logic [7:0]        r_acc;
    logic [3:0]        r_cnt;
    logic [63:0]       r_word;
    logic [3:0]        r_slen;
    logic              r_sum_rx;
    lmfe_pkg::t_result r_res;
    lmfe_pkg::t_result r_out;
    logic              r_out_valid;

    logic [IDX_W-1:0] ch_idx;
    logic             ch_ok;

    lmfe_pkg::t_phase cur_ph;
    logic [7:0]       cur_pid;
    logic [3:0]       cur_idx;
    logic [63:0]      cur_data;
    logic [3:0]       cur_len;
    logic             cur_dir;
    logic             cur_enh;
    logic [7:0]       cur_csum;
    logic             cur_done;
    logic             cur_taken;
    logic             cur_match;

    lmfe_pkg::t_phase n_ph;
    logic [7:0]       n_pid;
    logic [3:0]       n_idx;
    logic [63:0]      n_data;
    logic [3:0]       n_len;
    logic             n_dir;
    logic             n_enh;
    logic [7:0]       n_csum;
    logic             n_done;
    logic             n_taken;

    lmfe_pkg::t_result res;
    logic              need_sum;
    logic              sum_rx;
    logic [63:0]       sum_word;
    logic [3:0]        sum_len;
    logic [7:0]        sum_init;

    logic [3:0]  len_c;
    logic [7:0]  pid_new;
    logic [5:0]  sh;
    logic [7:0]  byte_sel;
    logic [3:0]  idx_inc;
    logic [63:0] len_mask;
    logic [8:0]  add9;
    logic [7:0]  acc_next;
    logic [7:0]  sum_val;

    assign ch_idx = IDX_W'(r_ch);
    assign ch_ok  = ({3'b000, r_ch} < 5'(NUM_CHANNELS));

    assign cur_ph    = r_phase[ch_idx];
    assign cur_pid   = r_pid[ch_idx];
    assign cur_idx   = r_idx[ch_idx];
    assign cur_data  = r_data[ch_idx];
    assign cur_len   = r_len[ch_idx];
    assign cur_dir   = r_dir[ch_idx];
    assign cur_enh   = r_enh[ch_idx];
    assign cur_csum  = r_csum[ch_idx];
    assign cur_done  = r_done[ch_idx];
    assign cur_taken = r_taken[ch_idx];
    assign cur_match = r_match[ch_idx];

    assign pid_new  = lmfe_pkg::make_pid(r_fid);
    assign sh       = {cur_idx[2:0], 3'b000};
    assign byte_sel = 8'(cur_data >> sh);
    assign idx_inc  = cur_idx + 4'd1;

    always_comb begin
        len_c = r_len_in;
        if (r_len_in == 4'd0) begin
            len_c = 4'd1;
        end else if (r_len_in > 4'(lmfe_pkg::MAX_DATA_BYTES)) begin
            len_c = 4'(lmfe_pkg::MAX_DATA_BYTES);
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            len_mask[8*i +: 8] = (4'(i) < cur_len) ? 8'hFF : 8'h00;
        end
    end

    always_comb begin
        n_ph     = cur_ph;
        n_pid    = cur_pid;
        n_idx    = cur_idx;
        n_data   = cur_data;
        n_len    = cur_len;
        n_dir    = cur_dir;
        n_enh    = cur_enh;
        n_csum   = cur_csum;
        n_done   = cur_done;
        n_taken  = cur_taken;
        res      = '0;
        need_sum = 1'b0;
        sum_rx   = 1'b0;
        sum_word = cur_data;
        sum_len  = cur_len;
        sum_init = cur_enh ? cur_pid : 8'h00;
        if (ch_ok) begin
            case (r_cmd)
                lmfe_pkg::CMD_SEND: begin
                    if (cur_ph == lmfe_pkg::PH_IDLE && cur_taken) begin
                        n_len        = len_c;
                        n_data       = r_fdata;
                        n_dir        = r_sresp;
                        n_enh        = r_enh_in;
                        n_pid        = pid_new;
                        n_done       = 1'b0;
                        n_ph         = lmfe_pkg::PH_BREAK;
                        res.accepted = 1'b1;
                        sum_word     = r_fdata;
                        sum_len      = len_c;
                        sum_init     = r_enh_in ? pid_new : 8'h00;
                        if (r_sresp) begin
                            n_taken = 1'b0;
                        end else begin
                            need_sum = 1'b1;
                        end
                    end
                end
                lmfe_pkg::CMD_TX_READY: begin
                    case (cur_ph)
                        lmfe_pkg::PH_BREAK: begin
                            res.tx_valid   = 1'b1;
                            res.tx_byte    = lmfe_pkg::BREAK_BYTE;
                            res.break_rate = 1'b1;
                            n_ph           = lmfe_pkg::PH_SYNC;
                        end
                        lmfe_pkg::PH_SYNC: begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = lmfe_pkg::SYNC_BYTE;
                            n_ph         = lmfe_pkg::PH_PID;
                        end
                        lmfe_pkg::PH_PID: begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = cur_pid;
                            n_idx        = 4'd0;
                            if (cur_dir) begin
                                n_ph   = lmfe_pkg::PH_RXDATA;
                                n_done = 1'b0;
                            end else begin
                                n_ph = lmfe_pkg::PH_TXDATA;
                            end
                        end
                        lmfe_pkg::PH_TXDATA: begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = byte_sel;
                            n_idx        = idx_inc;
                            if (idx_inc >= cur_len) begin
                                n_idx = 4'd0;
                                n_ph  = lmfe_pkg::PH_TXSUM;
                            end
                        end
                        lmfe_pkg::PH_TXSUM: begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = cur_csum;
                            n_ph         = lmfe_pkg::PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                lmfe_pkg::CMD_RX_BYTE: begin
                    if (cur_ph == lmfe_pkg::PH_RXDATA) begin
                        n_data = (cur_data & ~(64'hFF << sh)) | (64'(r_rx) << sh);
                        n_idx  = idx_inc;
                        if (idx_inc >= cur_len) begin
                            n_idx = 4'd0;
                            n_ph  = lmfe_pkg::PH_RXSUM;
                        end
                    end else if (cur_ph == lmfe_pkg::PH_RXSUM) begin
                        n_csum   = r_rx;
                        n_done   = 1'b1;
                        n_ph     = lmfe_pkg::PH_IDLE;
                        need_sum = 1'b1;
                        sum_rx   = 1'b1;
                    end
                end
                lmfe_pkg::CMD_FETCH: begin
                    if (cur_done) begin
                        n_taken            = 1'b1;
                        res.accepted       = 1'b1;
                        res.response_valid = 1'b1;
                        res.response_data  = cur_data & len_mask;
                        res.checksum_ok    = cur_match;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // end-around carry add
    assign add9     = {1'b0, r_acc} + {1'b0, r_word[7:0]};
    assign acc_next = add9[8] ? (add9[7:0] + 8'd1) : add9[7:0];
    assign sum_val  = ~r_acc;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_in) begin
            r_cmd    <= lmfe_pkg::t_cmd'(i_in_tuser);
            r_ch     <= i_in_tdata[1:0];
            r_fid    <= i_in_tdata[7:2];
            r_sresp  <= i_in_tdata[8];
            r_enh_in <= i_in_tdata[9];
            r_len_in <= i_in_tdata[13:10];
            r_fdata  <= i_in_tdata[77:14];
            r_rx     <= i_in_tdata[85:78];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec && ch_ok) begin
            r_data[ch_idx] <= n_data;
            r_len[ch_idx]  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_phase[c] <= lmfe_pkg::PH_IDLE;
                r_pid[c]   <= 8'h00;
                r_idx[c]   <= 4'd0;
                r_dir[c]   <= 1'b0;
                r_enh[c]   <= 1'b0;
                r_csum[c]  <= 8'hFF;
                r_done[c]  <= 1'b0;
                r_taken[c] <= 1'b1;
                r_match[c] <= 1'b0;
            end
        end else begin
            if (i_ctrl.exec && ch_ok) begin
                r_phase[ch_idx] <= n_ph;
                r_pid[ch_idx]   <= n_pid;
                r_idx[ch_idx]   <= n_idx;
                r_dir[ch_idx]   <= n_dir;
                r_enh[ch_idx]   <= n_enh;
                r_csum[ch_idx]  <= n_csum;
                r_done[ch_idx]  <= n_done;
                r_taken[ch_idx] <= n_taken;
            end
            if (i_ctrl.finish && ch_ok) begin
                if (r_sum_rx) begin
                    r_match[ch_idx] <= (r_csum[ch_idx] == sum_val);
                end else begin
                    r_csum[ch_idx] <= sum_val;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.exec) begin
            r_acc    <= sum_init;
            r_cnt    <= 4'd0;
            r_word   <= sum_word;
            r_slen   <= sum_len;
            r_sum_rx <= sum_rx;
            r_res    <= res;
        end else if (i_ctrl.sum_step) begin
            r_acc  <= acc_next;
            r_cnt  <= r_cnt + 4'd1;
            r_word <= r_word >> 8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_stat.need_sum = need_sum;
    assign o_stat.sum_last = ((r_cnt + 4'd1) == r_slen);
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_out_tdata     = r_out;

endmodule

// ===== verif/lin_master_frame_engine_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lin_master_frame_engine_checker
// Watches both stream channels of the lin master frame engine and keeps its
// own copy of every channel's frame state. Each accepted request produces
// one predicted reply, and each reply leaving the block is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module lin_master_frame_engine_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [lmfe_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic [1:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [lmfe_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_requests,
    output int                               o_sends,
    output int                               o_fetches,
    output int                               o_sums_ok
);

    import lmfe_pkg::*;

    t_phase      ch_phase     [NUM_CHANNELS];
    logic [7:0]  ch_pid       [NUM_CHANNELS];
    logic [3:0]  ch_index     [NUM_CHANNELS];
    logic [63:0] ch_data      [NUM_CHANNELS];
    logic [3:0]  ch_len       [NUM_CHANNELS];
    logic        ch_slave     [NUM_CHANNELS];
    logic        ch_enh       [NUM_CHANNELS];
    logic [7:0]  ch_sum       [NUM_CHANNELS];
    logic        ch_resp_done [NUM_CHANNELS];
    logic        ch_resp_free [NUM_CHANNELS];
    logic        ch_sum_match [NUM_CHANNELS];

    t_result reply_q [$];
    int      mismatches;
    int      requests;
    int      sends;
    int      fetches;
    int      sums_ok;

    function automatic logic [7:0] protect_id(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    // carry-around sum over the stored bytes, inverted
    function automatic logic [7:0] frame_checksum(input int c);
        logic [8:0] acc;
        acc = ch_enh[c] ? {1'b0, ch_pid[c]} : 9'd0;
        for (int i = 0; i < int'(ch_len[c]) && i < MAX_DATA_BYTES; i++) begin
            acc = acc + {1'b0, ch_data[c][i*8 +: 8]};
            if (acc[8]) begin
                acc = {1'b0, acc[7:0]} + 9'd1;
            end
        end
        return ~acc[7:0];
    endfunction

    function automatic t_result lin_step(input t_cmd cmd, input logic [85:0] f);
        t_result     r;
        int          c;
        logic [5:0]  id;
        logic [3:0]  len;
        logic [7:0]  rx;
        logic [63:0] mask;
        r   = '0;
        c   = int'(f[1:0]);
        id  = f[7:2];
        len = f[13:10];
        rx  = f[85:78];
        if (c < NUM_CHANNELS) begin
            case (cmd)
                CMD_SEND: begin
                    if (ch_phase[c] == PH_IDLE && ch_resp_free[c]) begin
                        if (len == 4'd0) len = 4'd1;
                        if (len > 4'(MAX_DATA_BYTES)) len = 4'(MAX_DATA_BYTES);
                        ch_len[c]       = len;
                        ch_data[c]      = f[77:14];
                        ch_slave[c]     = f[8];
                        ch_enh[c]       = f[9];
                        ch_pid[c]       = protect_id(id);
                        ch_resp_done[c] = 1'b0;
                        if (!ch_slave[c]) ch_sum[c] = frame_checksum(c);
                        else ch_resp_free[c] = 1'b0;
                        ch_phase[c] = PH_BREAK;
                        r.accepted  = 1'b1;
                        sends++;
                    end
                end
                CMD_TX_READY: begin
                    case (ch_phase[c])
                        PH_BREAK: begin
                            r.tx_valid   = 1'b1;
                            r.tx_byte    = BREAK_BYTE;
                            r.break_rate = 1'b1;
                            ch_phase[c]  = PH_SYNC;
                        end
                        PH_SYNC: begin
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = SYNC_BYTE;
                            ch_phase[c] = PH_PID;
                        end
                        PH_PID: begin
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ch_pid[c];
                            ch_index[c] = 4'd0;
                            if (!ch_slave[c]) begin
                                ch_phase[c] = PH_TXDATA;
                            end else begin
                                ch_phase[c]     = PH_RXDATA;
                                ch_resp_done[c] = 1'b0;
                            end
                        end
                        PH_TXDATA: begin
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ch_data[c][ch_index[c][2:0]*8 +: 8];
                            ch_index[c] = ch_index[c] + 4'd1;
                            if (ch_index[c] >= ch_len[c]) begin
                                ch_index[c] = 4'd0;
                                ch_phase[c] = PH_TXSUM;
                            end
                        end
                        PH_TXSUM: begin
                            r.tx_valid  = 1'b1;
                            r.tx_byte   = ch_sum[c];
                            ch_phase[c] = PH_IDLE;
                        end
                        default: begin
                        end
                    endcase
                end
                CMD_RX_BYTE: begin
                    if (ch_phase[c] == PH_RXDATA) begin
                        ch_data[c][ch_index[c][2:0]*8 +: 8] = rx;
                        ch_index[c] = ch_index[c] + 4'd1;
                        if (ch_index[c] >= ch_len[c]) begin
                            ch_index[c] = 4'd0;
                            ch_phase[c] = PH_RXSUM;
                        end
                    end else if (ch_phase[c] == PH_RXSUM) begin
                        ch_sum[c]       = rx;
                        ch_sum_match[c] = (rx == frame_checksum(c));
                        ch_resp_done[c] = 1'b1;
                        ch_phase[c]     = PH_IDLE;
                    end
                end
                CMD_FETCH: begin
                    if (ch_resp_done[c]) begin
                        mask = (ch_len[c] >= 4'd8) ? '1 : (64'd1 << (ch_len[c] * 8)) - 64'd1;
                        ch_resp_free[c]  = 1'b1;
                        r.accepted       = 1'b1;
                        r.response_valid = 1'b1;
                        r.response_data  = ch_data[c] & mask;
                        r.checksum_ok    = ch_sum_match[c];
                        fetches++;
                        if (ch_sum_match[c]) sums_ok++;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                ch_phase[c]     = PH_IDLE;
                ch_pid[c]       = 8'h00;
                ch_index[c]     = 4'd0;
                ch_data[c]      = '0;
                ch_len[c]       = 4'd0;
                ch_slave[c]     = 1'b0;
                ch_enh[c]       = 1'b0;
                ch_sum[c]       = 8'hFF;
                ch_resp_done[c] = 1'b0;
                ch_resp_free[c] = 1'b1;
                ch_sum_match[c] = 1'b0;
            end
            reply_q.delete();
            mismatches = 0;
            requests   = 0;
            sends      = 0;
            fetches    = 0;
            sums_ok    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_result'(m_axis_tdata);
                if (reply_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: reply with no request waiting: %h", $realtime,
                                 m_axis_tdata);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (got.accepted !== want.accepted || got.tx_valid !== want.tx_valid
                            || got.tx_byte !== want.tx_byte
                            || got.break_rate !== want.break_rate
                            || got.response_valid !== want.response_valid
                            || got.response_data !== want.response_data
                            || got.checksum_ok !== want.checksum_ok) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: reply mismatch", $realtime);
                            $display("  expected acc %b tx %b %h brk %b resp %b %h ok %b",
                                     want.accepted, want.tx_valid, want.tx_byte,
                                     want.break_rate, want.response_valid,
                                     want.response_data, want.checksum_ok);
                            $display("  actual   acc %b tx %b %h brk %b resp %b %h ok %b",
                                     got.accepted, got.tx_valid, got.tx_byte,
                                     got.break_rate, got.response_valid,
                                     got.response_data, got.checksum_ok);
                        end
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                reply_q.push_back(lin_step(t_cmd'(s_axis_tuser), s_axis_tdata[85:0]));
                requests++;
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= reply_q.size();
        o_requests   <= requests;
        o_sends      <= sends;
        o_fetches    <= fetches;
        o_sums_ok    <= sums_ok;
    end

endmodule

// ===== verif/lin_master_frame_engine_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lin_master_frame_engine_test
// Drives the lin master frame engine with a few directed corner cases and
// then with random complete frames interleaved over all channels, mixed with
// stray events. Both stream sides idle at random and the reply side holds
// off once for a long stretch. The checker beside the block predicts and
// compares every reply.
// ----------------------------------------------------------------------------
module lin_master_frame_engine_test;

    import lmfe_pkg::*;

    localparam int NUM_CH      = 4;
    localparam int REQUESTS    = 1750;
    localparam int HOLD_CYCLES = 500;

    typedef struct {
        t_cmd        cmd;
        logic [1:0]  ch;
        logic [5:0]  id;
        logic        slave;
        logic        enh;
        logic [3:0]  len;
        logic [63:0] data;
        logic [7:0]  rx;
    } t_request;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = CMD_SEND;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending;
    int requests;
    int sends;
    int fetches;
    int sums_ok;

    logic     calm = 1'b0;
    logic     hold_req = 1'b0;
    t_request frame_script [NUM_CH][$];

    lin_master_frame_engine #(
        .NUM_CHANNELS(NUM_CH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lin_master_frame_engine_checker #(
        .NUM_CHANNELS(NUM_CH)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_requests    (requests),
        .o_sends       (sends),
        .o_fetches     (fetches),
        .o_sums_ok     (sums_ok)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45) return 0;
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // checksum a slave has to send back for the bytes it answered with
    function automatic logic [7:0] slave_checksum(input logic [7:0] pid, input logic enh,
                                                  input logic [63:0] data, input int len);
        logic [8:0] acc;
        acc = enh ? {1'b0, pid} : 9'd0;
        for (int i = 0; i < len; i++) begin
            acc = acc + {1'b0, data[i*8 +: 8]};
            if (acc[8]) acc = {1'b0, acc[7:0]} + 9'd1;
        end
        return ~acc[7:0];
    endfunction

    function automatic t_request make_req(input t_cmd cmd, input logic [1:0] ch,
                                          input logic [5:0] id, input logic slave,
                                          input logic enh, input logic [3:0] len,
                                          input logic [63:0] data, input logic [7:0] rx);
        t_request r;
        r.cmd   = cmd;
        r.ch    = ch;
        r.id    = id;
        r.slave = slave;
        r.enh   = enh;
        r.len   = len;
        r.data  = data;
        r.rx    = rx;
        return r;
    endfunction

    function automatic t_request any_request();
        return make_req(t_cmd'($urandom_range(0, 3)), 2'($urandom), 6'($urandom),
                        1'($urandom), 1'($urandom), 4'($urandom), {$urandom, $urandom},
                        8'($urandom));
    endfunction

    task automatic offer(input t_request r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.cmd;
        s_axis_tdata  <= {2'b00, r.rx, r.data, r.len, r.enh, r.slave, r.id, r.ch};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic plan_frame(input logic [1:0] ch);
        t_request    s;
        int          eff;
        int          r;
        logic [63:0] rx_data;
        logic [7:0]  b;
        s       = any_request();
        s.cmd   = CMD_SEND;
        s.ch    = ch;
        rx_data = '0;
        if ($urandom_range(0, 9) == 0) begin
            r     = $urandom_range(0, 7);
            s.len = (r == 0) ? 4'd0 : 4'(8 + r);
        end else begin
            s.len = 4'($urandom_range(1, 8));
        end
        eff = (s.len == 4'd0) ? 1 : (s.len > 4'd8) ? 8 : int'(s.len);
        frame_script[ch].push_back(s);
        repeat (3) frame_script[ch].push_back(make_req(CMD_TX_READY, ch, 0, 0, 0, 0, 0, 0));
        if (!s.slave) begin
            repeat (eff + 1) begin
                frame_script[ch].push_back(make_req(CMD_TX_READY, ch, 0, 0, 0, 0, 0, 0));
            end
        end else begin
            for (int i = 0; i < eff; i++) begin
                r = $urandom_range(0, 9);
                b = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
                rx_data[i*8 +: 8] = b;
                frame_script[ch].push_back(make_req(CMD_RX_BYTE, ch, 0, 0, 0, 0, 0, b));
            end
            b = slave_checksum(make_pid(s.id), s.enh, rx_data, eff);
            if ($urandom_range(0, 3) == 0) b = b ^ 8'($urandom_range(1, 255));
            frame_script[ch].push_back(make_req(CMD_RX_BYTE, ch, 0, 0, 0, 0, 0, b));
            r = $urandom_range(0, 19);
            if (r < 19) frame_script[ch].push_back(make_req(CMD_FETCH, ch, 0, 0, 0, 0, 0, 0));
            if (r >= 16 && r < 19) begin
                frame_script[ch].push_back(make_req(CMD_FETCH, ch, 0, 0, 0, 0, 0, 0));
            end
        end
    endtask

    // reply side: random stalls, one long hold-off on request
    initial begin : reply_side
        int stall;
        int run;
        logic held;
        held = 1'b0;
        wait (i_rst_n);
        forever begin
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = pick_gap();
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                run = $urandom_range(1, 6);
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [63:0] rx_data;
        logic [7:0]  b;
        logic [1:0]  ch;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle channel corners
        offer(make_req(CMD_FETCH, 2'd3, 0, 0, 0, 0, 0, 0));
        offer(make_req(CMD_TX_READY, 2'd2, 0, 0, 0, 0, 0, 0));
        // master frame, zero length taken as one byte
        offer(make_req(CMD_SEND, 2'd0, 6'h3F, 1'b0, 1'b0, 4'd0, '1, 8'h00));
        repeat (5) offer(make_req(CMD_TX_READY, 2'd0, 0, 0, 0, 0, 0, 0));
        // slave frame, oversize length, enhanced sum, busy and unfetched sends
        offer(make_req(CMD_SEND, 2'd1, 6'h00, 1'b1, 1'b1, 4'd15, '0, 8'h00));
        offer(make_req(CMD_SEND, 2'd1, 6'h15, 1'b0, 1'b0, 4'd3, 64'h0123, 8'h00));
        repeat (4) offer(make_req(CMD_TX_READY, 2'd1, 0, 0, 0, 0, 0, 0));
        rx_data = '0;
        for (int i = 0; i < 8; i++) begin
            b = i[0] ? 8'h00 : 8'hFF;
            rx_data[i*8 +: 8] = b;
            offer(make_req(CMD_RX_BYTE, 2'd1, 0, 0, 0, 0, 0, b));
        end
        b = slave_checksum(make_pid(6'h00), 1'b1, rx_data, 8);
        offer(make_req(CMD_RX_BYTE, 2'd1, 0, 0, 0, 0, 0, b));
        offer(make_req(CMD_SEND, 2'd1, 6'h2A, 1'b0, 1'b1, 4'd2, 64'hBEEF, 8'h00));
        repeat (2) offer(make_req(CMD_FETCH, 2'd1, 0, 0, 0, 0, 0, 0));

        for (int n = 0; n < REQUESTS; n++) begin
            if (n % 160 == 0) calm = ($urandom_range(0, 3) == 0);
            if (n == 500) hold_req = 1'b1;
            ch = 2'($urandom_range(0, NUM_CH - 1));
            if ($urandom_range(0, 99) < 8) begin
                offer(any_request());
            end else begin
                if (frame_script[ch].size() == 0) plan_frame(ch);
                offer(frame_script[ch].pop_front());
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (40) @(posedge i_clk);

        $display("run covered %0d requests over %0d channels, %0d frames started",
                 requests, NUM_CH, sends);
        $display("%0d slave responses fetched, %0d of them with a matching checksum",
                 fetches, sums_ok);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
